[rtl/tus_pkg.sv]
// ----------------------------------------------------------------------------
// tus_pkg: shared types and constants of the triangle subdivider
// Holds the coordinate vector type, the controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tus_pkg;

    // Q16.16 coordinate and configuration widths
    localparam int COORD_W = 32;
    localparam int LVL_W   = 4;
    localparam int VEC_W   = 3 * COORD_W;
    localparam int IN_W    = 3 * VEC_W;
    localparam int OUT_W   = 3 * VEC_W;

    // Reset value of the level register
    localparam logic [LVL_W-1:0] LEVEL_RESET = 4'd8;

    // Step divider: 33-bit magnitude padded to 36 bits, 4 bits per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = 9;
    localparam int NUM_W      = DIV_BITS * DIV_STEPS;
    localparam int DIV_CNT_W  = 4;
    localparam int DIV_LANES  = 6;

    // One point: x in the lowest bits, then y, then z
    typedef logic [2:0][COORD_W-1:0] t_vec;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_SUM,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch level, corner A and differences, start division
        logic div_step;     // one divider step on all lanes
        logic finish;       // form signed steps, reset walk to corner A
        logic sum;          // form s1 + s2
        logic emit;         // load output register
        logic emit_second;  // second subtriangle of the cell
        logic emit_last;    // last subtriangle of the triangle
        logic next_col;     // advance point by s2
        logic next_row;     // advance row by s1, restart point
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [LVL_W-1:0] lvl;       // level latched for this triangle
        logic             out_free;  // output register can take a request
    } t_dp_stat;

endpackage

[rtl/tus_ctrl.sv]
// ----------------------------------------------------------------------------
// tus_ctrl: sequencer of the triangle subdivider
// Walks division, setup and the row/column emission order of the
// subtriangles, and drives the datapath through command bundles.
// ----------------------------------------------------------------------------
module tus_ctrl #(
    parameter int MAX_LEVEL = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tus_pkg::t_dp_stat i_stat,
    output tus_pkg::t_dp_cmd  o_cmd
);
    import tus_pkg::*;

    localparam int CNT_W = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_phase, n_phase;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    logic row_end;
    logic tri_last;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_phase   <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_phase   <= n_phase;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign row_end  = (r_j == r_i);
    assign tri_last = (LVL_W'(r_i) == (i_stat.lvl - LVL_W'(1))) && row_end && !r_phase;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_phase    = r_phase;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Take no request while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_i       = '0;
                n_j       = '0;
                n_phase   = 1'b0;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                // Emit one subtriangle whenever the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_second = r_phase;
                    if (r_phase) begin
                        n_phase        = 1'b0;
                        n_j            = r_j + CNT_W'(1);
                        o_cmd.next_col = 1'b1;
                    end else if (!row_end) begin
                        n_phase = 1'b1;
                    end else if (tri_last) begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        n_i            = r_i + CNT_W'(1);
                        n_j            = '0;
                        o_cmd.next_row = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Column never passes the row inside a walk
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_j <= r_i))
        else $error("column index beyond row index");

    // Second subtriangle only in cells left of the diagonal
    a_second_off_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_phase) |-> (r_j < r_i))
        else $error("second subtriangle on the diagonal");

    // Row stays below the latched level
    a_row_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (LVL_W'(r_i) < i_stat.lvl))
        else $error("row index beyond level");

    // The last subtriangle ends the walk
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == ST_IDLE))
        else $error("walk continued after last subtriangle");
`endif

endmodule

[rtl/tus_dp.sv]
// ----------------------------------------------------------------------------
// tus_dp: datapath of the triangle subdivider
// Holds the level register, six step divider lanes, the walk registers
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module tus_dp #(
    parameter int MAX_LEVEL = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tus_pkg::LVL_W-1:0]  i_cfg_wr_data,
    input  logic [tus_pkg::IN_W-1:0]   i_s_tdata,
    input  tus_pkg::t_dp_cmd           i_cmd,
    output tus_pkg::t_dp_stat          o_stat,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [tus_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                       o_m_tlast
);
    import tus_pkg::*;

    logic [LVL_W-1:0]   r_level;
    logic [LVL_W-1:0]   r_lvl;
    logic [LVL_W-1:0]   lvl_eff;
    t_vec               r_a;
    logic [DIV_LANES-1:0] r_neg, n_neg;
    logic [NUM_W-1:0]   r_num [DIV_LANES];
    logic [NUM_W-1:0]   n_num [DIV_LANES];
    logic [LVL_W-1:0]   r_rem [DIV_LANES];
    logic [LVL_W-1:0]   n_rem [DIV_LANES];
    logic [COORD_W-1:0] r_quo [DIV_LANES];
    logic [COORD_W-1:0] n_quo [DIV_LANES];
    logic [NUM_W-1:0]   ld_num [DIV_LANES];
    t_vec               r_s1, r_s2, r_s12;
    t_vec               r_row, r_pt;
    t_vec               in_a, in_b, in_c;
    t_vec               n_s1, n_s2;
    t_vec               v0, v1, v2;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_last;
    logic               r_out_valid;

    assign in_a = i_s_tdata[VEC_W-1:0];
    assign in_b = i_s_tdata[2*VEC_W-1:VEC_W];
    assign in_c = i_s_tdata[3*VEC_W-1:2*VEC_W];

    // Clamp level into 1..MAX_LEVEL
    always_comb begin
        if (r_level == '0) begin
            lvl_eff = LVL_W'(1);
        end else if (r_level > LVL_W'(MAX_LEVEL)) begin
            lvl_eff = LVL_W'(MAX_LEVEL);
        end else begin
            lvl_eff = r_level;
        end
    end

    // Level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else if (i_cfg_wr_en) begin
            r_level <= i_cfg_wr_data;
        end
    end

    // Differences and their magnitudes: lanes 0..2 are C-A, lanes 3..5 are B-C
    always_comb begin
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        mag;
        for (int k = 0; k < 3; k++) begin
            d = {in_c[k][COORD_W-1], in_c[k]} - {in_a[k][COORD_W-1], in_a[k]};
            n_neg[k]      = d[COORD_W];
            mag           = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
            ld_num[k]     = NUM_W'(mag);
            d = {in_b[k][COORD_W-1], in_b[k]} - {in_c[k][COORD_W-1], in_c[k]};
            n_neg[k + 3]  = d[COORD_W];
            mag           = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
            ld_num[k + 3] = NUM_W'(mag);
        end
    end

    // Four restoring division steps per lane per cycle
    always_comb begin
        logic [NUM_W-1:0]   num;
        logic [LVL_W-1:0]   rem;
        logic [COORD_W-1:0] quo;
        for (int l = 0; l < DIV_LANES; l++) begin
            num = r_num[l];
            rem = r_rem[l];
            quo = r_quo[l];
            for (int b = 0; b < DIV_BITS; b++) begin
                rem = {rem[LVL_W-2:0], num[NUM_W-1]};
                num = {num[NUM_W-2:0], 1'b0};
                quo = {quo[COORD_W-2:0], 1'b0};
                if (rem >= r_lvl) begin
                    rem    = rem - r_lvl;
                    quo[0] = 1'b1;
                end
            end
            n_num[l] = num;
            n_rem[l] = rem;
            n_quo[l] = quo;
        end
    end

    // Apply sign to quotients, wrapped to 32 bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1[k] = r_neg[k]     ? (~r_quo[k]     + COORD_W'(1)) : r_quo[k];
            n_s2[k] = r_neg[k + 3] ? (~r_quo[k + 3] + COORD_W'(1)) : r_quo[k + 3];
        end
    end

    // Divider lanes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lvl <= lvl_eff;
            r_a   <= in_a;
            r_neg <= n_neg;
            for (int l = 0; l < DIV_LANES; l++) begin
                r_num[l] <= ld_num[l];
                r_rem[l] <= '0;
                r_quo[l] <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                r_num[l] <= n_num[l];
                r_rem[l] <= n_rem[l];
                r_quo[l] <= n_quo[l];
            end
        end
    end

    // Steps and walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_row <= r_a;
            r_pt  <= r_a;
        end else if (i_cmd.next_row) begin
            for (int k = 0; k < 3; k++) begin
                r_row[k] <= r_row[k] + r_s1[k];
                r_pt[k]  <= r_row[k] + r_s1[k];
            end
        end else if (i_cmd.next_col) begin
            for (int k = 0; k < 3; k++) begin
                r_pt[k] <= r_pt[k] + r_s2[k];
            end
        end
        if (i_cmd.sum) begin
            for (int k = 0; k < 3; k++) begin
                r_s12[k] <= r_s1[k] + r_s2[k];
            end
        end
    end

    // Subtriangle vertices from the current point
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v0[k] = r_pt[k];
            v1[k] = r_pt[k] + (i_cmd.emit_second ? r_s2[k] : r_s12[k]);
            v2[k] = r_pt[k] + (i_cmd.emit_second ? r_s12[k] : r_s1[k]);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {v2, v1, v0};
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_stat.lvl      = r_lvl;
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_m_tlast       = r_out_last;

endmodule

[rtl/triangle_uniform_subdivider_core.sv]
// ----------------------------------------------------------------------------
// triangle_uniform_subdivider_core: uniform triangle subdivision
// Splits a Q16.16 triangle into level*level subtriangles, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one triangle (corners A, B, C) per request. The master
//   stream returns level*level subtriangles in row order; tlast marks the
//   last one of each triangle. i_cfg_wr_en/i_cfg_wr_data write the level
//   (0 acts as 1, values above MAX_LEVEL saturate); write it while idle.
//   The level is sampled when a triangle is accepted.
// Sequence:
//   After acceptance, six divider lanes form the steps (C-A)/level and
//   (B-C)/level at four quotient bits per cycle; then the setup states
//   ST_FIN and ST_SUM form the signed steps and their sum. Subtriangles
//   follow one per cycle while the receiver is ready, and no new triangle is
//   taken before the last one is emitted. The next triangle is accepted
//   while the last subtriangle still waits in the output register.
// Reset and stall:
//   Reset (synchronous, active low) sets level to 8 and empties the output
//   register. A stalled receiver holds the output register and the walk.
// ----------------------------------------------------------------------------
module triangle_uniform_subdivider_core #(
    parameter int MAX_LEVEL = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration: subdivision_level
    input  logic                      i_cfg_wr_en,
    input  logic [tus_pkg::LVL_W-1:0] i_cfg_wr_data,
    // Triangle in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // corner_c_x, corner_c_y, corner_c_z (32 bits each, lowest first)
    input  logic [tus_pkg::IN_W-1:0]  s_axis_tdata,
    // Subtriangles out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    // vert2_x, vert2_y, vert2_z (32 bits each, lowest first)
    output logic [tus_pkg::OUT_W-1:0] m_axis_tdata,
    // final_piece
    output logic                      m_axis_tlast
);
    import tus_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    tus_ctrl #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    tus_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tlast     (m_axis_tlast)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: triangle subdivider stream check
// Streams triangles into the subdivider under several level settings and
// compares every subtriangle against a predicted split of the same triangle.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------

// One expected subtriangle: nine packed coordinates and the last flag
typedef struct {
    logic [tus_pkg::OUT_W-1:0] verts;
    logic                      last;
} t_piece;

// ----------------------------------------------------------------------------
// Holds the predicted subtriangles of accepted triangles, oldest first
// ----------------------------------------------------------------------------
class subtri_scoreboard;
    t_piece expected_pieces[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return expected_pieces.size();
    endfunction

    // Store one vertex, wrapped to 32 bits per coordinate
    function void put_vertex(ref t_piece pc, input int slot, input longint v[3]);
        for (int k = 0; k < 3; k++) begin
            pc.verts[(slot * 3 + k) * tus_pkg::COORD_W +: tus_pkg::COORD_W] = v[k][31:0];
        end
    endfunction

    // Split one accepted triangle into its expected subtriangles
    function void note_triangle(logic [tus_pkg::IN_W-1:0] triangle,
                                logic [tus_pkg::LVL_W-1:0] level_reg);
        longint a[3], b[3], c[3], s1[3], s2[3];
        longint p[3], p1[3], p2[3], p13[3];
        longint lvl;
        t_piece pc;
        lvl = longint'(level_reg);
        // Zero acts as one, anything above the maximum saturates
        if (lvl < 1) lvl = 1;
        if (lvl > 8) lvl = 8;
        for (int k = 0; k < 3; k++) begin
            a[k]  = $signed(triangle[k * 32 +: 32]);
            b[k]  = $signed(triangle[96 + k * 32 +: 32]);
            c[k]  = $signed(triangle[192 + k * 32 +: 32]);
            s1[k] = (c[k] - a[k]) / lvl;
            s2[k] = (b[k] - c[k]) / lvl;
        end
        for (int idx = 1; idx <= lvl; idx++) begin
            for (int j = 0; j < idx; j++) begin
                for (int k = 0; k < 3; k++) begin
                    p[k]   = a[k] + longint'(idx - 1) * s1[k] + longint'(j) * s2[k];
                    p1[k]  = p[k] + s1[k];
                    p2[k]  = p[k] + s2[k];
                    p13[k] = p[k] + s1[k] + s2[k];
                end
                put_vertex(pc, 0, p);
                put_vertex(pc, 1, p13);
                put_vertex(pc, 2, p1);
                pc.last = 1'b0;
                expected_pieces = {expected_pieces, pc};
                if (j < idx - 1) begin
                    put_vertex(pc, 0, p);
                    put_vertex(pc, 1, p2);
                    put_vertex(pc, 2, p13);
                    expected_pieces = {expected_pieces, pc};
                end
            end
        end
        expected_pieces[$].last = 1'b1;
    endfunction

    // Compare one accepted subtriangle with the oldest expectation
    function void check_piece(logic [tus_pkg::OUT_W-1:0] verts, logic last);
        t_piece exp_pc;
        string  fname;
        logic [31:0] want, got;
        if (expected_pieces.size() == 0) begin
            $error("unexpected subtriangle %h last %b", verts, last);
            errors++;
            return;
        end
        exp_pc = expected_pieces.pop_front();
        for (int f = 0; f < 9; f++) begin
            want  = exp_pc.verts[f * 32 +: 32];
            got   = verts[f * 32 +: 32];
            fname = $sformatf("vert%0d_%s", f / 3, (f % 3 == 0) ? "x" : (f % 3 == 1) ? "y" : "z");
            if (want !== got) begin
                $error("%s: expected %h, actual %h", fname, want, got);
                errors++;
            end
        end
        if (exp_pc.last !== last) begin
            $error("final_piece: expected %b, actual %b", exp_pc.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import tus_pkg::*;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_ONE = 32'h0001_0000;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 11;
    localparam int HOLD_CYCLES    = 400;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [LVL_W-1:0] i_cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    subtri_scoreboard board = new();
    logic [LVL_W-1:0] level_now = LEVEL_RESET;
    bit               quiet = 1'b0;
    bit               hold_request = 1'b0;
    int               hold_left = 0;
    logic [IN_W-1:0]  tri_word;
    logic [LVL_W-1:0] phase_levels[NUM_PHASES];

    triangle_uniform_subdivider_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock: 2 ns period
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hold reset low, then release it
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Pack corners with all three coordinates of a corner equal
    function automatic logic [IN_W-1:0] corners(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic [IN_W-1:0] d;
        for (int k = 0; k < 3; k++) begin
            d[k * 32 +: 32]       = a;
            d[96 + k * 32 +: 32]  = b;
            d[192 + k * 32 +: 32] = c;
        end
        return d;
    endfunction

    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 4))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Draw a triangle: wide random, close-together corners, or edge values
    function automatic logic [IN_W-1:0] random_triangle();
        logic [IN_W-1:0] d;
        logic [31:0]     base[3];
        int unsigned     mode;
        mode = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) base[k] = $urandom;
        for (int f = 0; f < 9; f++) begin
            if (mode < 40)
                d[f * 32 +: 32] = $urandom;
            else if (mode < 75)
                d[f * 32 +: 32] = base[f % 3] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            else
                d[f * 32 +: 32] = edge_coord();
        end
        return d;
    endfunction

    // Offer one triangle and hold it until the request is taken
    task automatic send_triangle(input logic [IN_W-1:0] triangle);
        bit taken;
        taken = 1'b0;
        while (!quiet && $urandom_range(0, 99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= triangle;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            if (taken) board.note_triangle(triangle, level_now);
            @(posedge i_clk);
        end
    endtask

    // Drop valid, let every expected subtriangle drain, then write the level
    task automatic write_level(input logic [LVL_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        level_now = value;
    endtask

    // Receiver: random ready, one long hold-off on request, check at mid-cycle
    initial begin
        repeat (7) @(posedge i_clk);
        forever begin
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
            end
            @(negedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                board.check_piece(m_axis_tdata, m_axis_tlast);
            @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin
        repeat (8) @(posedge i_clk);

        // Edge corners at the reset level
        send_triangle(corners(32'h0, 32'h0, 32'h0));
        send_triangle(corners(C_MAX, C_MAX, C_MAX));
        send_triangle(corners(C_MIN, C_MIN, C_MIN));
        send_triangle(corners(C_MIN, C_MAX, C_MAX));
        send_triangle(corners(C_MAX, C_MIN, C_MIN));
        send_triangle(corners(C_MIN, C_MIN, C_MAX));
        send_triangle(corners(C_MAX, C_MAX, C_MIN));
        // Steps that truncate toward zero on both signs
        send_triangle(corners(32'h0, 32'hFFFF_FFF3, 32'd11));
        tri_word = corners(C_ONE, 32'hFFFE_0000, 32'h0003_8000);
        tri_word[32 +: 32]  = C_MIN;
        tri_word[256 +: 32] = C_MAX;
        send_triangle(tri_word);

        // Level zero acts as one
        write_level(4'd0);
        send_triangle(corners(32'h0, C_ONE, 2 * C_ONE));
        send_triangle(corners(C_MIN, C_MAX, 32'h0));
        send_triangle(random_triangle());

        // Level above the maximum saturates
        write_level(4'd15);
        send_triangle(corners(32'hFFFF_FFF3, 32'd11, C_MAX));
        send_triangle(random_triangle());
        send_triangle(random_triangle());

        write_level(4'd1);
        send_triangle(corners(C_MAX, C_MIN, C_MAX));
        send_triangle(random_triangle());

        write_level(4'd3);
        send_triangle(corners(32'd1, 32'hFFFF_FFFE, 32'd5));
        send_triangle(corners(C_MIN, C_MAX, C_MIN));
        send_triangle(random_triangle());

        // Random phases, each at its own level
        phase_levels = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd7,
                         4'd4, 4'd6, 4'd3, 4'd9};
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_level(ph < 7 ? phase_levels[ph] : LVL_W'($urandom_range(0, 15)));
            quiet = (ph == 4);
            if (ph == 2) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_triangle(random_triangle());
        end

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tus_pkg.sv
rtl/tus_ctrl.sv
rtl/tus_dp.sv
rtl/triangle_uniform_subdivider_core.sv
tb/sv/testbench.sv
